// ===== design/stp_pkg.sv =====
// shared types, codes and keyword tables for the sql token parser
package stp_pkg;

    localparam int COLUMN_LIMIT_DEF = 16;
    localparam int NAME_BYTES_DEF   = 32;
    localparam int VALUE_BYTES_DEF  = 64;

    // result queue between parser and output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // token kinds
    localparam logic [3:0] K_KEYWORD = 4'd0;
    localparam logic [3:0] K_IDENT   = 4'd1;
    localparam logic [3:0] K_NUMBER  = 4'd2;
    localparam logic [3:0] K_STRING  = 4'd3;
    localparam logic [3:0] K_LPAREN  = 4'd4;
    localparam logic [3:0] K_RPAREN  = 4'd5;
    localparam logic [3:0] K_COMMA   = 4'd6;
    localparam logic [3:0] K_STAR    = 4'd7;
    localparam logic [3:0] K_EQ      = 4'd8;
    localparam logic [3:0] K_LT      = 4'd9;
    localparam logic [3:0] K_GT      = 4'd10;
    localparam logic [3:0] K_EOF     = 4'd11;

    // result item kinds
    localparam logic [2:0] IK_STMT   = 3'd0;
    localparam logic [2:0] IK_TABLE  = 3'd1;
    localparam logic [2:0] IK_COLUMN = 3'd2;
    localparam logic [2:0] IK_VALUE  = 3'd3;
    localparam logic [2:0] IK_WCOL   = 3'd4;
    localparam logic [2:0] IK_OP     = 3'd5;
    localparam logic [2:0] IK_WVAL   = 3'd6;
    localparam logic [2:0] IK_STATUS = 3'd7;

    // status codes
    localparam logic [1:0] S_OK     = 2'd0;
    localparam logic [1:0] S_SYNTAX = 2'd1;
    localparam logic [1:0] S_MANY   = 2'd2;
    localparam logic [1:0] S_UNSUP  = 2'd3;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [4:0] {
        ST_FIRST, ST_INS_INTO, ST_INS_TABLE, ST_INS_LP, ST_INS_COL, ST_INS_CSEP,
        ST_INS_VKW, ST_INS_VLP, ST_INS_VAL, ST_INS_VSEP, ST_SEL_FIRST, ST_SEL_COL,
        ST_SEL_CSEP, ST_SEL_FROM, ST_SEL_TABLE, ST_SEL_AFTER, ST_SEL_WCOL,
        ST_SEL_OP, ST_SEL_WVAL, ST_DONE
    } t_gstate;

    typedef enum logic [1:0] {R_NONE, R_KW, R_NAME, R_VALUE} t_role;

    typedef enum logic [2:0] {
        KW_INSERT, KW_SELECT, KW_INTO, KW_VALUES, KW_FROM, KW_WHERE
    } t_kw;

    typedef struct packed {
        logic [2:0] item_kind;
        logic [3:0] slot;
        logic [5:0] char_index;
        logic [7:0] payload;
        logic       numeric;
        logic       all_columns;
        logic [4:0] column_total;
        logic       last;
    } t_result;

    // up to two results caused by one input word
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_qhead;

    function automatic logic [5:0] kw_len(input t_kw kw);
        logic [5:0] len;
        unique case (kw)
            KW_INTO, KW_FROM: len = 6'd4;
            KW_WHERE:         len = 6'd5;
            default:          len = 6'd6;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input t_kw kw, input logic [5:0] pos);
        logic [47:0] txt;
        logic [7:0]  ch;
        unique case (kw)
            KW_INSERT: txt = "insert";
            KW_SELECT: txt = "select";
            KW_INTO:   txt = {"into", 16'h0};
            KW_VALUES: txt = "values";
            KW_FROM:   txt = {"from", 16'h0};
            KW_WHERE:  txt = {"where", 8'h0};
            default:   txt = '0;
        endcase
        ch = '0;
        if (pos < 6'd6) begin
            ch = txt[8 * (5 - int'(pos)) +: 8];
        end
        return ch;
    endfunction

    // keyword compare: only 'A'..'Z' fold to lower case
    function automatic logic kw_char_ok(input t_kw kw, input logic [5:0] pos,
                                        input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            f = c + CASE_OFFSET;
        end
        return (pos < kw_len(kw)) && (f == kw_char(kw, pos));
    endfunction

endpackage

// ===== design/sql_statement_token_parser_unit.sv =====
// top level of the sql statement token parser
// results of an accepted word are registered in the result queue and leave it on the master side
// throughput: one input word per cycle while the queue has room; a word that causes two
//   results sends them as two output words in turn, and the four-record queue absorbs such bursts
// reset: synchronous, active low; clears the grammar state and empties the queue
module sql_statement_token_parser_unit #(
    parameter int COLUMN_LIMIT = stp_pkg::COLUMN_LIMIT_DEF,
    parameter int NAME_BYTES   = stp_pkg::NAME_BYTES_DEF,
    parameter int VALUE_BYTES  = stp_pkg::VALUE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // char_byte[7:0], token_end[8], zero[15:9]
    input  logic [4:0]  s_axis_tuser,  // token_kind[3:0], char_present[4]
    input  logic        s_axis_tlast,  // statement_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot[3:0], char_index[9:4], payload[17:10], numeric[18], all_columns[19],
    // column_total[24:20], zero[31:25]
    output logic [31:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,  // item_kind[2:0]
    output logic        m_axis_tlast   // last
);
    import stp_pkg::*;

    t_push   w_push;
    t_qhead  w_head;
    t_result w_res;
    logic    w_q_ready;
    logic    w_pop;
    logic    w_accept;

    assign s_axis_tready = w_q_ready;
    assign w_accept      = s_axis_tvalid && w_q_ready;

    stp_front #(
        .COLUMN_LIMIT(COLUMN_LIMIT),
        .NAME_BYTES  (NAME_BYTES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_token_kind   (s_axis_tuser[3:0]),
        .i_char_byte    (s_axis_tdata[7:0]),
        .i_char_present (s_axis_tuser[4]),
        .i_token_end    (s_axis_tdata[8]),
        .i_statement_end(s_axis_tlast),
        .o_push         (w_push)
    );

    stp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_ready(w_q_ready),
        .o_head (w_head),
        .i_pop  (w_pop)
    );

    stp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_result(w_res)
    );

    assign m_axis_tdata = {7'd0, w_res.column_total, w_res.all_columns, w_res.numeric,
                           w_res.payload, w_res.char_index, w_res.slot};
    assign m_axis_tuser = w_res.item_kind;
    assign m_axis_tlast = w_res.last;

endmodule

// ===== design/stp_front.sv =====
// front part: grammar tracking and classification of each input word
module stp_front #(
    parameter int COLUMN_LIMIT = stp_pkg::COLUMN_LIMIT_DEF,
    parameter int NAME_BYTES   = stp_pkg::NAME_BYTES_DEF,
    parameter int VALUE_BYTES  = stp_pkg::VALUE_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [3:0]    i_token_kind,
    input  logic [7:0]    i_char_byte,
    input  logic          i_char_present,
    input  logic          i_token_end,
    input  logic          i_statement_end,
    output stp_pkg::t_push o_push
);
    import stp_pkg::*;

    localparam int CW = $clog2(COLUMN_LIMIT + 1);
    localparam logic [CW-1:0] COL_LIM  = CW'(COLUMN_LIMIT);
    localparam logic [5:0]    NAME_LIM = 6'(NAME_BYTES - 1);
    localparam logic [5:0]    VAL_LIM  = 6'(VALUE_BYTES - 1);

    t_gstate       r_gs, n_gs;
    logic [1:0]    r_km, n_km;
    logic [5:0]    r_pos, n_pos;
    logic [CW-1:0] r_ccnt, n_ccnt;
    logic [CW-1:0] r_vcnt, n_vcnt;
    logic          r_skind, n_skind;
    logic [1:0]    r_status, n_status;
    logic          r_star, n_star;
    logic          r_in_tok, n_in_tok;
    logic          r_soft, n_soft;
    logic          r_isnum, n_isnum;
    t_role         r_role, n_role;
    t_gstate       r_next, n_next;
    t_kw           r_kw, n_kw;
    logic [2:0]    r_out, n_out;
    logic [3:0]    r_slot, n_slot;

    t_result       v_res [2];
    logic [1:0]    v_n;
    logic          v_fail;
    logic [1:0]    v_code;
    t_kw           v_second;
    logic [5:0]    v_lim;
    logic [1:0]    v_st;

    always_comb begin
        n_gs = r_gs; n_km = r_km; n_pos = r_pos; n_ccnt = r_ccnt; n_vcnt = r_vcnt;
        n_skind = r_skind; n_status = r_status; n_star = r_star; n_in_tok = r_in_tok;
        n_soft = r_soft; n_isnum = r_isnum; n_role = r_role; n_next = r_next;
        n_kw = r_kw; n_out = r_out; n_slot = r_slot;
        v_res[0] = '0;
        v_res[1] = '0;
        v_n = 2'd0;
        v_fail = 1'b0;
        v_code = S_OK;
        v_second = KW_SELECT;
        v_lim = NAME_LIM;
        v_st = S_OK;

        if (i_accept) begin
            // token start
            if (!r_in_tok) begin
                n_pos = '0;
                if (r_gs != ST_DONE) begin
                    n_role = R_NONE; n_next = r_gs; n_soft = 1'b0; n_isnum = 1'b0;
                    unique case (r_gs)
                        ST_FIRST: begin
                            if (i_token_kind == K_EOF) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else if (i_token_kind == K_KEYWORD) begin
                                n_role = R_KW; n_kw = KW_INSERT; n_km = 2'b11;
                            end else begin
                                v_fail = 1'b1; v_code = S_UNSUP;
                            end
                        end
                        ST_INS_INTO, ST_INS_VKW, ST_SEL_FROM: begin
                            if (i_token_kind != K_KEYWORD) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_role = R_KW; n_km = 2'b01;
                                unique case (r_gs)
                                    ST_INS_INTO: begin
                                        n_kw = KW_INTO; n_next = ST_INS_TABLE;
                                    end
                                    ST_INS_VKW: begin
                                        n_kw = KW_VALUES; n_next = ST_INS_VLP;
                                    end
                                    default: begin
                                        n_kw = KW_FROM; n_next = ST_SEL_TABLE;
                                    end
                                endcase
                            end
                        end
                        ST_INS_TABLE, ST_SEL_TABLE, ST_SEL_WCOL: begin
                            if (i_token_kind != K_IDENT) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_role = R_NAME; n_slot = '0;
                                unique case (r_gs)
                                    ST_INS_TABLE: begin
                                        n_out = IK_TABLE; n_next = ST_INS_LP;
                                    end
                                    ST_SEL_TABLE: begin
                                        n_out = IK_TABLE; n_next = ST_SEL_AFTER;
                                    end
                                    default: begin
                                        n_out = IK_WCOL; n_next = ST_SEL_OP;
                                    end
                                endcase
                            end
                        end
                        ST_INS_LP, ST_INS_VLP: begin
                            if (i_token_kind != K_LPAREN) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_next = (r_gs == ST_INS_LP) ? ST_INS_COL : ST_INS_VAL;
                            end
                        end
                        ST_INS_COL, ST_SEL_COL, ST_SEL_FIRST: begin
                            if (r_gs == ST_SEL_FIRST && i_token_kind == K_STAR) begin
                                n_star = 1'b1; n_next = ST_SEL_FROM;
                            end else if (i_token_kind != K_IDENT) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else if (r_ccnt >= COL_LIM) begin
                                v_fail = 1'b1; v_code = S_MANY;
                            end else begin
                                n_role = R_NAME; n_out = IK_COLUMN; n_slot = 4'(r_ccnt);
                                n_next = (r_gs == ST_INS_COL) ? ST_INS_CSEP : ST_SEL_CSEP;
                                n_ccnt = r_ccnt + CW'(1);
                            end
                        end
                        ST_INS_CSEP: begin
                            if (i_token_kind == K_COMMA) begin
                                n_next = ST_INS_COL;
                            end else if (i_token_kind != K_RPAREN) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_next = ST_INS_VKW;
                            end
                        end
                        ST_INS_VAL: begin
                            if (i_token_kind != K_NUMBER && i_token_kind != K_STRING) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else if (r_vcnt >= COL_LIM) begin
                                v_fail = 1'b1; v_code = S_MANY;
                            end else begin
                                n_role = R_VALUE; n_out = IK_VALUE; n_slot = 4'(r_vcnt);
                                n_next = ST_INS_VSEP;
                                n_isnum = (i_token_kind == K_NUMBER);
                                n_vcnt = r_vcnt + CW'(1);
                            end
                        end
                        ST_INS_VSEP: begin
                            if (i_token_kind == K_COMMA) begin
                                n_next = ST_INS_VAL;
                            end else if (i_token_kind != K_RPAREN || r_vcnt != r_ccnt) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_next = ST_DONE;
                            end
                        end
                        ST_SEL_CSEP: begin
                            if (i_token_kind == K_COMMA) begin
                                n_next = ST_SEL_COL;
                            end else if (i_token_kind != K_KEYWORD) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_role = R_KW; n_kw = KW_FROM; n_km = 2'b01;
                                n_next = ST_SEL_TABLE;
                            end
                        end
                        ST_SEL_AFTER: begin
                            // optional where clause, anything else closes the statement
                            if (i_token_kind == K_KEYWORD) begin
                                n_role = R_KW; n_kw = KW_WHERE; n_km = 2'b01;
                                n_next = ST_SEL_WCOL; n_soft = 1'b1;
                            end else begin
                                n_next = ST_DONE;
                            end
                        end
                        ST_SEL_OP: begin
                            if (i_token_kind < K_EQ || i_token_kind > K_GT) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                v_res[0] = '0;
                                v_res[0].item_kind = IK_OP;
                                v_res[0].payload = 8'(i_token_kind - K_EQ + 4'd1);
                                v_n = 2'd1;
                                n_next = ST_SEL_WVAL;
                            end
                        end
                        ST_SEL_WVAL: begin
                            if (i_token_kind != K_NUMBER && i_token_kind != K_STRING) begin
                                v_fail = 1'b1; v_code = S_SYNTAX;
                            end else begin
                                n_role = R_VALUE; n_out = IK_WVAL; n_slot = '0;
                                n_next = ST_DONE;
                                n_isnum = (i_token_kind == K_NUMBER);
                            end
                        end
                        default: n_next = ST_DONE;
                    endcase
                    if (v_fail) begin
                        n_status = v_code; n_gs = ST_DONE; n_role = R_NONE; n_next = ST_DONE;
                    end
                end else begin
                    n_role = R_NONE;
                end
            end

            // character of the current token
            if (i_char_present && n_gs != ST_DONE) begin
                if (n_role == R_KW) begin
                    v_second = (n_kw == KW_INSERT) ? KW_SELECT : n_kw;
                    if (!kw_char_ok(n_kw, n_pos, i_char_byte)) n_km[0] = 1'b0;
                    if (!kw_char_ok(v_second, n_pos, i_char_byte)) n_km[1] = 1'b0;
                end else if (n_role == R_NAME || n_role == R_VALUE) begin
                    v_lim = (n_role == R_NAME) ? NAME_LIM : VAL_LIM;
                    if (n_pos < v_lim) begin
                        v_res[v_n[0]] = '0;
                        v_res[v_n[0]].item_kind = n_out;
                        v_res[v_n[0]].slot = n_slot;
                        v_res[v_n[0]].char_index = n_pos;
                        v_res[v_n[0]].payload = i_char_byte;
                        v_res[v_n[0]].numeric = n_isnum;
                        v_n = v_n + 2'd1;
                    end
                end
            end
            if (i_char_present && n_pos < 6'd63) n_pos = n_pos + 6'd1;

            // token end
            if (i_token_end || i_statement_end) begin
                n_in_tok = 1'b0;
                if (n_gs != ST_DONE) begin
                    if (n_role == R_KW && n_kw == KW_INSERT) begin
                        if (n_km[0] && n_pos == kw_len(KW_INSERT)) begin
                            n_skind = 1'b0; n_gs = ST_INS_INTO;
                            v_res[v_n[0]] = '0;
                            v_res[v_n[0]].item_kind = IK_STMT;
                            v_n = v_n + 2'd1;
                        end else if (n_km[1] && n_pos == kw_len(KW_SELECT)) begin
                            n_skind = 1'b1; n_gs = ST_SEL_FIRST;
                            v_res[v_n[0]] = '0;
                            v_res[v_n[0]].item_kind = IK_STMT;
                            v_res[v_n[0]].payload = 8'd1;
                            v_n = v_n + 2'd1;
                        end else begin
                            n_status = S_UNSUP; n_gs = ST_DONE;
                            n_role = R_NONE; n_next = ST_DONE;
                        end
                    end else if (n_role == R_KW) begin
                        if (n_km[0] && n_pos == kw_len(n_kw)) begin
                            n_gs = n_next;
                        end else if (n_soft) begin
                            n_gs = ST_DONE;
                        end else begin
                            n_status = S_SYNTAX; n_gs = ST_DONE;
                            n_role = R_NONE; n_next = ST_DONE;
                        end
                    end else begin
                        n_gs = n_next;
                    end
                end
            end else begin
                n_in_tok = 1'b1;
            end

            // statement end: status word, then back to the start
            if (i_statement_end) begin
                v_st = n_status;
                if (n_gs != ST_DONE) v_st = (n_gs == ST_SEL_AFTER) ? S_OK : S_SYNTAX;
                v_res[v_n[0]] = '0;
                v_res[v_n[0]].item_kind = IK_STATUS;
                v_res[v_n[0]].payload = 8'(v_st);
                v_res[v_n[0]].all_columns = n_star;
                v_res[v_n[0]].column_total = (n_ccnt > CW'(31)) ? 5'd31 : 5'(n_ccnt);
                v_res[v_n[0]].last = 1'b1;
                v_n = v_n + 2'd1;
                n_gs = ST_FIRST; n_km = 2'b11; n_pos = '0; n_ccnt = '0; n_vcnt = '0;
                n_skind = 1'b0; n_status = S_OK; n_star = 1'b0; n_in_tok = 1'b0;
                n_soft = 1'b0; n_isnum = 1'b0; n_role = R_NONE; n_next = ST_FIRST;
                n_kw = KW_INSERT; n_out = '0; n_slot = '0;
            end
        end

        o_push.valid   = i_accept && (v_n != 2'd0);
        o_push.rec.two = v_n[1];
        o_push.rec.r0  = v_res[0];
        o_push.rec.r1  = v_res[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs <= ST_FIRST; r_km <= 2'b11; r_pos <= '0; r_ccnt <= '0; r_vcnt <= '0;
            r_skind <= 1'b0; r_status <= S_OK; r_star <= 1'b0; r_in_tok <= 1'b0;
            r_soft <= 1'b0; r_isnum <= 1'b0; r_role <= R_NONE; r_next <= ST_FIRST;
            r_kw <= KW_INSERT; r_out <= '0; r_slot <= '0;
        end else begin
            r_gs <= n_gs; r_km <= n_km; r_pos <= n_pos; r_ccnt <= n_ccnt; r_vcnt <= n_vcnt;
            r_skind <= n_skind; r_status <= n_status; r_star <= n_star;
            r_in_tok <= n_in_tok; r_soft <= n_soft; r_isnum <= n_isnum;
            r_role <= n_role; r_next <= n_next; r_kw <= n_kw; r_out <= n_out;
            r_slot <= n_slot;
        end
    end

endmodule

// ===== design/stp_queue.sv =====
// short queue of result records between parser and output stage
module stp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stp_pkg::t_push  i_push,
    output logic            o_ready,
    output stp_pkg::t_qhead o_head,
    input  logic            i_pop
);
    import stp_pkg::*;

    t_rec            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            v_pop;

    always_comb begin
        v_pop = i_pop && (r_cnt != '0);
        n_wr  = i_push.valid ? r_wr + Q_AW'(1) : r_wr;
        n_rd  = v_pop ? r_rd + Q_AW'(1) : r_rd;
        n_cnt = r_cnt + (Q_AW + 1)'(i_push.valid) - (Q_AW + 1)'(v_pop);
    end

    assign o_ready      = (r_cnt != (Q_AW + 1)'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.rec;
        end
    end

endmodule

// ===== design/stp_back.sv =====
// back part: sends the one or two results of each record as output words
module stp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  stp_pkg::t_qhead i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output stp_pkg::t_result o_result
);
    import stp_pkg::*;

    logic r_second, n_second;

    always_comb begin
        o_valid  = i_head.valid;
        o_result = r_second ? i_head.rec.r1 : i_head.rec.r0;
        // record leaves the queue once its final result is taken
        o_pop    = i_head.valid && i_ready && (r_second || !i_head.rec.two);
        n_second = r_second;
        if (i_head.valid && i_ready) begin
            n_second = i_head.rec.two && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

endmodule

// ===== design/stp_checker.sv =====
// port-level checks for the sql statement token parser, bound to the top level
module stp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import stp_pkg::*;

    // held word stays put until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // status words and only they close a statement
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == IK_STATUS)))
        else $error("tlast does not match status word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[17:10] < 8'd4 && m_axis_tdata[9:0] == 10'd0
            && m_axis_tdata[24:20] <= 5'd16 + 5'd15)
        else $error("bad status word");

    a_op_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == IK_OP |->
            m_axis_tdata[17:10] >= 8'd1 && m_axis_tdata[17:10] <= 8'd3)
        else $error("where operator out of range");

    // nothing comes out at reset release without input
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output word right after reset");

endmodule

bind sql_statement_token_parser_unit stp_checker u_stp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

// ===== verif/sql_statement_token_parser_unit_test.sv =====
// self-checking testbench for the sql statement token parser unit
module sql_statement_token_parser_unit_test;
    import stp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 150;
    localparam int PREDICTED   = -1;
    localparam logic [3:0] K_UNUSED = 4'd15;  // kinds above eof and other match nothing

    typedef logic [7:0] t_text[$];

    typedef struct {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       present;
        logic       tend;
        logic       send;
        int         exp_status;  // typed status for one-word statements, else predicted
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // char_byte[7:0], token_end[8], zero[15:9]
    logic [4:0]  s_axis_tuser = '0;   // token_kind[3:0], char_present[4]
    logic        s_axis_tlast = 1'b0; // statement_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // slot[3:0], char_index[9:4], payload[17:10], numeric[18], all_columns[19],
    // column_total[24:20], zero[31:25]
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;        // item_kind[2:0]
    logic        m_axis_tlast;        // last

    sql_statement_token_parser_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    int fails = 0;
    int cycles = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    t_result results_due[$];
    t_result fresh[$];
    t_word   stmt_words[$];

    // parser state mirror
    t_gstate    gst;
    logic [1:0] kmask;
    logic [5:0] cpos;
    logic [4:0] ncol, nval;
    logic [1:0] stat;
    logic       star_seen;
    logic       mid_token, tk_soft, tk_num;
    logic [3:0] tk_kind;
    t_role      tk_role;
    t_gstate    tk_next;
    t_kw        tk_kw;
    logic [2:0] tk_out;
    logic [3:0] tk_slot;

    string kw_spell [6] = '{"insert", "select", "into", "values", "from", "where"};

    // directed words: error codes on one-word statements, case folding, kind of later chars
    t_word dir_rows [19] = '{
        '{K_EOF,     8'h00, 1'b0, 1'b1, 1'b1, S_SYNTAX},
        '{K_UNUSED,  8'hff, 1'b1, 1'b1, 1'b1, S_UNSUP},
        '{K_KEYWORD, 8'h00, 1'b0, 1'b1, 1'b1, S_UNSUP},
        '{K_IDENT,   "x",   1'b1, 1'b1, 1'b1, S_UNSUP},
        '{K_KEYWORD, "i",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "N",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "s",   1'b1, 1'b0, 1'b1, S_UNSUP},
        '{K_KEYWORD, "S",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "e",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "L",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "e",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "C",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "t",   1'b1, 1'b1, 1'b0, PREDICTED},
        '{K_STAR,    "*",   1'b1, 1'b1, 1'b0, PREDICTED},
        '{K_KEYWORD, "F",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_EOF,     "R",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "O",   1'b1, 1'b0, 1'b0, PREDICTED},
        '{K_KEYWORD, "M",   1'b1, 1'b1, 1'b0, PREDICTED},
        '{K_IDENT,   8'h7f, 1'b1, 1'b1, 1'b1, PREDICTED}
    };

    function automatic void add_result(logic [2:0] kind, logic [3:0] slot, logic [5:0] idx,
                                       logic [7:0] payload, logic isnum, logic allc,
                                       logic [4:0] tot, logic last);
        t_result r;
        r.item_kind = kind;
        r.slot = slot;
        r.char_index = idx;
        r.payload = payload;
        r.numeric = isnum;
        r.all_columns = allc;
        r.column_total = tot;
        r.last = last;
        fresh.push_back(r);
    endfunction

    function automatic logic kw_fits(t_kw k, logic [5:0] pos, logic [7:0] c);
        string spell;
        logic [7:0] f;
        spell = kw_spell[int'(k)];
        f = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        return (int'(pos) < spell.len()) && (f == 8'(spell[int'(pos)]));
    endfunction

    function automatic void new_statement();
        gst = ST_FIRST;
        kmask = 2'b11;
        cpos = '0;
        ncol = '0;
        nval = '0;
        stat = S_OK;
        star_seen = 1'b0;
        mid_token = 1'b0;
        tk_soft = 1'b0;
        tk_num = 1'b0;
        tk_kind = '0;
        tk_role = R_NONE;
        tk_next = ST_FIRST;
        tk_kw = KW_INSERT;
        tk_out = '0;
        tk_slot = '0;
    endfunction

    function automatic void abandon(logic [1:0] code);
        stat = code;
        gst = ST_DONE;
        tk_role = R_NONE;
        tk_next = ST_DONE;
    endfunction

    function automatic void need_kw(t_kw k, t_gstate nxt);
        if (tk_kind != K_KEYWORD) begin
            abandon(S_SYNTAX);
        end else begin
            tk_role = R_KW;
            tk_kw = k;
            kmask = 2'b01;
            tk_next = nxt;
        end
    endfunction

    function automatic void need_name(logic [2:0] ik, logic [3:0] sl, t_gstate nxt);
        if (tk_kind != K_IDENT) begin
            abandon(S_SYNTAX);
        end else begin
            tk_role = R_NAME;
            tk_out = ik;
            tk_slot = sl;
            tk_next = nxt;
        end
    endfunction

    function automatic void need_value(logic [2:0] ik, logic [3:0] sl, t_gstate nxt);
        if (tk_kind != K_NUMBER && tk_kind != K_STRING) begin
            abandon(S_SYNTAX);
        end else begin
            tk_role = R_VALUE;
            tk_out = ik;
            tk_slot = sl;
            tk_next = nxt;
            tk_num = (tk_kind == K_NUMBER);
        end
    endfunction

    function automatic void need_punct(logic [3:0] kind, t_gstate nxt);
        if (tk_kind != kind) abandon(S_SYNTAX);
        else tk_next = nxt;
    endfunction

    function automatic void need_column(t_gstate nxt);
        if (tk_kind != K_IDENT) begin
            abandon(S_SYNTAX);
        end else if (ncol >= COLUMN_LIMIT_DEF) begin
            abandon(S_MANY);
        end else begin
            need_name(IK_COLUMN, ncol[3:0], nxt);
            ncol++;
        end
    endfunction

    // grammar step taken on the first word of a token
    function automatic void begin_token();
        tk_role = R_NONE;
        tk_next = gst;
        tk_soft = 1'b0;
        tk_num = 1'b0;
        case (gst)
            ST_FIRST: begin
                if (tk_kind == K_EOF) begin
                    abandon(S_SYNTAX);
                end else if (tk_kind == K_KEYWORD) begin
                    // insert and select are both candidates until the text decides
                    tk_role = R_KW;
                    tk_kw = KW_INSERT;
                    kmask = 2'b11;
                end else begin
                    abandon(S_UNSUP);
                end
            end
            ST_INS_INTO:  need_kw(KW_INTO, ST_INS_TABLE);
            ST_INS_TABLE: need_name(IK_TABLE, 4'd0, ST_INS_LP);
            ST_INS_LP:    need_punct(K_LPAREN, ST_INS_COL);
            ST_INS_COL:   need_column(ST_INS_CSEP);
            ST_INS_CSEP: begin
                if (tk_kind == K_COMMA) tk_next = ST_INS_COL;
                else need_punct(K_RPAREN, ST_INS_VKW);
            end
            ST_INS_VKW:   need_kw(KW_VALUES, ST_INS_VLP);
            ST_INS_VLP:   need_punct(K_LPAREN, ST_INS_VAL);
            ST_INS_VAL: begin
                if (tk_kind != K_NUMBER && tk_kind != K_STRING) begin
                    abandon(S_SYNTAX);
                end else if (nval >= COLUMN_LIMIT_DEF) begin
                    abandon(S_MANY);
                end else begin
                    need_value(IK_VALUE, nval[3:0], ST_INS_VSEP);
                    nval++;
                end
            end
            ST_INS_VSEP: begin
                if (tk_kind == K_COMMA) tk_next = ST_INS_VAL;
                else if (tk_kind != K_RPAREN || nval != ncol) abandon(S_SYNTAX);
                else tk_next = ST_DONE;
            end
            ST_SEL_FIRST: begin
                if (tk_kind == K_STAR) begin
                    star_seen = 1'b1;
                    tk_next = ST_SEL_FROM;
                end else begin
                    need_column(ST_SEL_CSEP);
                end
            end
            ST_SEL_COL:   need_column(ST_SEL_CSEP);
            ST_SEL_CSEP: begin
                if (tk_kind == K_COMMA) tk_next = ST_SEL_COL;
                else need_kw(KW_FROM, ST_SEL_TABLE);
            end
            ST_SEL_FROM:  need_kw(KW_FROM, ST_SEL_TABLE);
            ST_SEL_TABLE: need_name(IK_TABLE, 4'd0, ST_SEL_AFTER);
            ST_SEL_AFTER: begin
                // any other keyword here just ends the statement quietly
                if (tk_kind == K_KEYWORD) begin
                    need_kw(KW_WHERE, ST_SEL_WCOL);
                    tk_soft = 1'b1;
                end else begin
                    tk_next = ST_DONE;
                end
            end
            ST_SEL_WCOL:  need_name(IK_WCOL, 4'd0, ST_SEL_OP);
            ST_SEL_OP: begin
                if (tk_kind < K_EQ || tk_kind > K_GT) begin
                    abandon(S_SYNTAX);
                end else begin
                    add_result(IK_OP, 4'd0, 6'd0, 8'(tk_kind - K_EQ + 4'd1),
                               1'b0, 1'b0, 5'd0, 1'b0);
                    tk_next = ST_SEL_WVAL;
                end
            end
            ST_SEL_WVAL:  need_value(IK_WVAL, 4'd0, ST_DONE);
            default:      tk_next = ST_DONE;
        endcase
    endfunction

    function automatic void end_token();
        if (gst == ST_DONE) return;
        if (tk_role == R_KW && tk_kw == KW_INSERT) begin
            if (kmask[0] && cpos == 6'd6) begin
                gst = ST_INS_INTO;
                add_result(IK_STMT, 4'd0, 6'd0, 8'd0, 1'b0, 1'b0, 5'd0, 1'b0);
            end else if (kmask[1] && cpos == 6'd6) begin
                gst = ST_SEL_FIRST;
                add_result(IK_STMT, 4'd0, 6'd0, 8'd1, 1'b0, 1'b0, 5'd0, 1'b0);
            end else begin
                abandon(S_UNSUP);
            end
        end else if (tk_role == R_KW) begin
            if (kmask[0] && int'(cpos) == kw_spell[int'(tk_kw)].len()) gst = tk_next;
            else if (tk_soft) gst = ST_DONE;
            else abandon(S_SYNTAX);
        end else begin
            gst = tk_next;
        end
    endfunction

    // works out the results one accepted word causes, into fresh
    function automatic void parse_word(t_word w);
        t_kw        alt;
        logic [5:0] lim;
        logic [1:0] st;
        fresh.delete();
        if (!mid_token) begin
            tk_kind = w.kind;
            cpos = '0;
            if (gst != ST_DONE) begin_token();
            else tk_role = R_NONE;
        end
        if (w.present && gst != ST_DONE) begin
            if (tk_role == R_KW) begin
                alt = (tk_kw == KW_INSERT) ? KW_SELECT : tk_kw;
                if (!kw_fits(tk_kw, cpos, w.ch)) kmask[0] = 1'b0;
                if (!kw_fits(alt, cpos, w.ch)) kmask[1] = 1'b0;
            end else if (tk_role == R_NAME || tk_role == R_VALUE) begin
                lim = (tk_role == R_NAME) ? 6'(NAME_BYTES_DEF - 1) : 6'(VALUE_BYTES_DEF - 1);
                if (cpos < lim) begin
                    add_result(tk_out, tk_slot, cpos, w.ch, tk_num, 1'b0, 5'd0, 1'b0);
                end
            end
        end
        if (w.present && cpos < 6'd63) cpos++;
        if (w.tend || w.send) begin
            end_token();
            mid_token = 1'b0;
        end else begin
            mid_token = 1'b1;
        end
        if (w.send) begin
            st = stat;
            if (gst != ST_DONE) st = (gst == ST_SEL_AFTER) ? S_OK : S_SYNTAX;
            add_result(IK_STATUS, 4'd0, 6'd0, 8'(st), 1'b0, star_seen, ncol, 1'b1);
            new_statement();
        end
    endfunction

    task automatic drive_word(t_word w);
        t_result r;
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, w.tend, w.ch};
        s_axis_tuser <= {w.present, w.kind};
        s_axis_tlast <= w.send;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_word(w);
        if (w.exp_status == PREDICTED) begin
            foreach (fresh[i]) results_due.push_back(fresh[i]);
        end else begin
            r = '0;
            r.item_kind = IK_STATUS;
            r.payload = 8'(w.exp_status);
            r.last = 1'b1;
            results_due.push_back(r);
        end
    endtask

    // sender holds off until the output side has drained
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_text kw_text(string s);
        t_text t;
        for (int i = 0; i < s.len(); i++) begin
            t.push_back(($urandom_range(0, 1) != 0) ? 8'(s[i]) - 8'd32 : 8'(s[i]));
        end
        // occasionally a misspelled, clipped or stretched keyword
        if ($urandom_range(0, 99) < 6) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(97, 122));
        if ($urandom_range(0, 99) < 4) t.push_back(8'($urandom_range(97, 122)));
        if ($urandom_range(0, 99) < 4) void'(t.pop_back());
        return t;
    endfunction

    function automatic t_text rand_ident(bit brief);
        t_text t;
        int n;
        n = brief ? 1 : ($urandom_range(0, 99) < 6 ? $urandom_range(30, 40) : $urandom_range(1, 4));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       t.push_back(8'($urandom_range(48, 57)));
                1:       t.push_back(8'($urandom_range(65, 90)));
                2:       t.push_back("_");
                default: t.push_back(8'($urandom_range(97, 122)));
            endcase
        end
        return t;
    endfunction

    function automatic t_text rand_value(bit num, bit brief);
        t_text t;
        int n;
        if (!brief && $urandom_range(0, 99) < 5) n = $urandom_range(60, 70);
        else n = num ? $urandom_range(1, 5) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            t.push_back(num ? 8'($urandom_range(48, 57)) : 8'($urandom_range(0, 255)));
        end
        return t;
    endfunction

    function automatic t_text rand_bytes(int n);
        t_text t;
        for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(0, 255)));
        return t;
    endfunction

    function automatic t_text punct(logic [7:0] c);
        t_text t;
        if ($urandom_range(0, 99) >= 10) t.push_back(c);
        return t;
    endfunction

    // one token as words; later chars carry junk kinds and empty words now and then
    function automatic void put_tok(logic [3:0] kind, t_text t);
        t_word w;
        if (t.size() == 0) begin
            w = '{kind, 8'h00, 1'b0, 1'b1, 1'b0, PREDICTED};
            stmt_words.push_back(w);
            return;
        end
        foreach (t[i]) begin
            if (i > 0 && $urandom_range(0, 99) < 8) begin
                w = '{4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0,
                      PREDICTED};
                stmt_words.push_back(w);
            end
            w.kind = (i == 0 || $urandom_range(0, 3) != 0) ? kind : 4'($urandom_range(0, 15));
            w.ch = t[i];
            w.present = 1'b1;
            w.tend = (i == t.size() - 1);
            w.send = 1'b0;
            w.exp_status = PREDICTED;
            stmt_words.push_back(w);
        end
    endfunction

    function automatic void build_statement();
        int pick, n, nv, k;
        bit num, cut;
        logic [3:0] opk;
        logic [7:0] op_ch;
        stmt_words.delete();
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            n = ($urandom_range(0, 99) < 8) ? COLUMN_LIMIT_DEF : $urandom_range(1, 4);
            nv = n;
            if ($urandom_range(0, 99) < 12) nv = ($urandom_range(0, 1) != 0) ? n + 1 : n - 1;
            put_tok(K_KEYWORD, kw_text("insert"));
            put_tok(K_KEYWORD, kw_text("into"));
            put_tok(K_IDENT, rand_ident(1'b0));
            put_tok(K_LPAREN, punct("("));
            for (int i = 0; i < n; i++) begin
                if (i > 0) put_tok(K_COMMA, punct(","));
                put_tok(K_IDENT, rand_ident(n > 4));
            end
            put_tok(K_RPAREN, punct(")"));
            put_tok(K_KEYWORD, kw_text("values"));
            put_tok(K_LPAREN, punct("("));
            for (int i = 0; i < nv; i++) begin
                if (i > 0) put_tok(K_COMMA, punct(","));
                num = $urandom_range(0, 1);
                put_tok(num ? K_NUMBER : K_STRING, rand_value(num, nv > 4));
            end
            put_tok(K_RPAREN, punct(")"));
        end else if (pick < 85) begin
            put_tok(K_KEYWORD, kw_text("select"));
            k = $urandom_range(0, 99);
            if (k < 35) begin
                put_tok(K_STAR, punct("*"));
            end else begin
                n = (k < 50) ? $urandom_range(COLUMN_LIMIT_DEF + 1, COLUMN_LIMIT_DEF + 2)
                             : $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) put_tok(K_COMMA, punct(","));
                    put_tok(K_IDENT, rand_ident(n > 3));
                end
            end
            put_tok(K_KEYWORD, kw_text("from"));
            put_tok(K_IDENT, rand_ident(1'b0));
            k = $urandom_range(0, 99);
            if (k < 55) begin
                put_tok(K_KEYWORD, kw_text("where"));
                put_tok(K_IDENT, rand_ident(1'b0));
                case ($urandom_range(0, 2))
                    0:       opk = K_EQ;
                    1:       opk = K_LT;
                    default: opk = K_GT;
                endcase
                op_ch = (opk == K_EQ) ? "=" : (opk == K_LT) ? "<" : ">";
                if ($urandom_range(0, 99) < 8) opk = 4'($urandom_range(0, 15));
                put_tok(opk, punct(op_ch));
                num = $urandom_range(0, 1);
                put_tok(num ? K_NUMBER : K_STRING, rand_value(num, 1'b0));
            end else if (k < 65) begin
                put_tok(K_KEYWORD, kw_text(($urandom_range(0, 1) != 0) ? "limit" : "order"));
            end
        end else begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                if (i == 0 && $urandom_range(0, 99) < 30) begin
                    put_tok(K_KEYWORD, rand_ident(1'b0));
                end else begin
                    put_tok(4'($urandom_range(0, 15)), rand_bytes($urandom_range(0, 3)));
                end
            end
        end
        // broken sequences: a word of the wrong kind, an early end, or trailing junk tokens
        if ($urandom_range(0, 99) < 12) begin
            stmt_words[$urandom_range(0, stmt_words.size() - 1)].kind = 4'($urandom_range(0, 15));
        end
        cut = ($urandom_range(0, 99) < 12) && (stmt_words.size() > 1);
        if (cut) begin
            n = $urandom_range(1, stmt_words.size() - 1);
            repeat (n) void'(stmt_words.pop_back());
        end else if ($urandom_range(0, 99) < 25) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                put_tok(4'($urandom_range(0, 15)), rand_bytes($urandom_range(0, 3)));
            end
        end
        stmt_words[stmt_words.size() - 1].send = 1'b1;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(1, 100) > snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("result with nothing expected: item_kind %0d payload %0d",
                       m_axis_tuser, m_axis_tdata[17:10]);
                fails++;
            end else begin
                want = results_due.pop_front();
                check_field("item_kind", want.item_kind, m_axis_tuser);
                check_field("slot", want.slot, m_axis_tdata[3:0]);
                check_field("char_index", want.char_index, m_axis_tdata[9:4]);
                check_field("payload", want.payload, m_axis_tdata[17:10]);
                check_field("numeric", want.numeric, m_axis_tdata[18]);
                check_field("all_columns", want.all_columns, m_axis_tdata[19]);
                check_field("column_total", want.column_total, m_axis_tdata[24:20]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int sent;
        new_statement();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) drive_word(dir_rows[i]);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase
            sent = 0;
            while (sent < PHASE_WORDS) begin
                build_statement();
                foreach (stmt_words[i]) drive_word(stmt_words[i]);
                sent += stmt_words.size();
            end
            drain();
        end
        // catch anything extra the block still emits
        repeat (8) @(posedge i_clk);
        if (fails == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

// ===== sql_statement_token_parser_unit.f =====
design/stp_pkg.sv
design/stp_front.sv
design/stp_queue.sv
design/stp_back.sv
design/sql_statement_token_parser_unit.sv
design/stp_checker.sv
verif/sql_statement_token_parser_unit_test.sv
